>>> design/kss_pkg.sv
// Shared types and constants for the k-th smallest select unit.
// No dependencies; imported by the select engine and the top level.
`default_nettype none

package kss_pkg;

  localparam int SAMPLE_W      = 32;
  localparam int RANK_W        = 8;
  localparam int MAX_ITEMS_DEF = 256;

  // Result status codes carried on the output tuser.
  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_RANK     = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_t;

  // Top level: loading samples or waiting on the select engine.
  typedef enum logic {
    TOP_LOAD,
    TOP_SELECT
  } top_state_t;

  // Select engine sequencer.
  typedef enum logic [4:0] {
    E_IDLE,
    E_CHECK,
    E_END_LO,
    E_END_HI,
    E_END_K,
    E_M0,
    E_M1,
    E_M2,
    E_M3,
    E_C0,
    E_C1,
    E_C2,
    E_W0,
    E_W1,
    E_W2,
    E_SI,
    E_SJ,
    E_SW,
    E_FIN
  } eng_state_t;

  // Engine to top: one-cycle pulse with the selected sample.
  typedef struct packed {
    logic                       valid;
    logic signed [SAMPLE_W-1:0] value;
  } kss_result_t;

endpackage

`default_nettype wire

>>> design/kss_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies; a read at the address being written returns the old data.
`default_nettype none

module kss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> design/kss_engine.sv
// Quickselect sequencer with median-of-three pivots over the sample RAM.
// Depends on kss_pkg; drives the RAM ports that the top level routes to kss_ram.
`default_nettype none

module kss_engine
  import kss_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF,
  localparam int AW       = $clog2(MAX_ITEMS)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [AW-1:0]       last_idx,
  input  logic [AW-1:0]       rank_idx,
  output kss_result_t         result,
  output logic                ram_we,
  output logic [AW-1:0]       ram_waddr,
  output logic [SAMPLE_W-1:0] ram_wdata,
  output logic [AW-1:0]       ram_raddr,
  input  logic [SAMPLE_W-1:0] ram_rdata
);

  eng_state_t state, state_next;

  logic [AW-1:0] lo, hi, i, j, k;
  logic signed [SAMPLE_W-1:0] p, q, r, vs, vi;
  logic                       fwd;
  logic signed [SAMPLE_W-1:0] fwd_data;
  logic signed [SAMPLE_W-1:0] rd_data;
  logic                       res_valid;
  logic signed [SAMPLE_W-1:0] res_value;

  logic [AW:0]   sum_lh, lo1, lo2;
  logic [AW-1:0] mid, i_inc, j_dec;
  logic          few_left, pair, mid_is_lo1, lt_piv, gt_piv, j_lt_i;

  assign result = '{valid: res_valid, value: res_value};

  // A read issued in the same cycle as a write to that entry sees the new data.
  assign rd_data = fwd ? fwd_data : ram_rdata;

  assign sum_lh     = {1'b0, lo} + {1'b0, hi};
  assign mid        = sum_lh[AW:1];
  assign lo1        = {1'b0, lo} + (AW+1)'(1);
  assign lo2        = {1'b0, lo} + (AW+1)'(2);
  assign few_left   = ({1'b0, hi} <= lo1);
  assign pair       = ({1'b0, hi} == lo1);
  assign mid_is_lo1 = (mid == lo1[AW-1:0]);
  assign i_inc      = i + AW'(1);
  assign j_dec      = j - AW'(1);
  assign lt_piv     = (rd_data < q);
  assign gt_piv     = (rd_data > q);
  assign j_lt_i     = (j < i);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = '0;
    ram_raddr  = '0;
    unique case (state)
      E_IDLE: begin
        if (start) begin
          state_next = E_CHECK;
        end
      end
      E_CHECK: begin
        if (few_left) begin
          if (pair) begin
            ram_raddr  = lo;
            state_next = E_END_LO;
          end else begin
            ram_raddr  = k;
            state_next = E_END_K;
          end
        end else begin
          ram_raddr  = mid;
          state_next = E_M0;
        end
      end
      E_END_LO: begin
        ram_raddr  = hi;
        state_next = E_END_HI;
      end
      E_END_HI: state_next = E_IDLE;
      E_END_K:  state_next = E_IDLE;
      E_M0: begin
        ram_raddr  = lo1[AW-1:0];
        state_next = E_M1;
      end
      E_M1: begin
        ram_raddr  = lo;
        state_next = E_M2;
      end
      E_M2: begin
        ram_raddr  = hi;
        state_next = E_M3;
      end
      E_M3: state_next = E_C0;
      E_C0: state_next = E_C1;
      E_C1: state_next = E_C2;
      E_C2: state_next = E_W0;
      E_W0: begin
        ram_we     = !mid_is_lo1;
        ram_waddr  = mid;
        ram_wdata  = vs;
        state_next = E_W1;
      end
      E_W1: begin
        ram_we     = 1'b1;
        ram_waddr  = lo1[AW-1:0];
        ram_wdata  = p;
        state_next = E_W2;
      end
      E_W2: begin
        ram_we     = 1'b1;
        ram_waddr  = hi;
        ram_wdata  = r;
        ram_raddr  = lo2[AW-1:0];
        state_next = E_SI;
      end
      E_SI: begin
        if (lt_piv) begin
          ram_raddr = i_inc;
        end else begin
          ram_raddr  = j_dec;
          state_next = E_SJ;
        end
      end
      E_SJ: begin
        if (gt_piv) begin
          ram_raddr = j_dec;
        end else if (j_lt_i) begin
          ram_we     = 1'b1;
          ram_waddr  = lo;
          ram_wdata  = rd_data;
          state_next = E_FIN;
        end else begin
          ram_we     = 1'b1;
          ram_waddr  = i;
          ram_wdata  = rd_data;
          state_next = E_SW;
        end
      end
      E_SW: begin
        ram_we     = 1'b1;
        ram_waddr  = j;
        ram_wdata  = vi;
        ram_raddr  = i_inc;
        state_next = E_SI;
      end
      E_FIN: begin
        ram_we     = 1'b1;
        ram_waddr  = j;
        ram_wdata  = q;
        state_next = (j == k) ? E_IDLE : E_CHECK;
      end
      default: state_next = E_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      fwd       <= 1'b0;
    end else begin
      res_valid <= 1'b0;
      fwd       <= ram_we && (ram_waddr == ram_raddr);
      case (state)
        E_END_HI: res_valid <= 1'b1;
        E_END_K:  res_valid <= 1'b1;
        E_FIN:    res_valid <= (j == k);
        default:  res_valid <= 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    fwd_data <= ram_wdata;
    case (state)
      E_IDLE: begin
        if (start) begin
          lo <= '0;
          hi <= last_idx;
          k  <= rank_idx;
        end
      end
      E_END_LO: p <= rd_data;
      E_END_HI: begin
        // Two entries left: the rank sits at the lower or the upper one.
        if ((k == lo) == (rd_data < p)) begin
          res_value <= rd_data;
        end else begin
          res_value <= p;
        end
      end
      E_END_K: res_value <= rd_data;
      E_M0:    p  <= rd_data;
      E_M1:    vs <= rd_data;
      E_M2:    q  <= rd_data;
      E_M3:    r  <= rd_data;
      E_C0: begin
        if (p > r) begin
          p <= r;
          r <= p;
        end
      end
      E_C1: begin
        if (q > r) begin
          q <= r;
          r <= q;
        end
      end
      E_C2: begin
        if (p > q) begin
          p <= q;
          q <= p;
        end
      end
      E_W2: begin
        i <= lo2[AW-1:0];
        j <= hi;
      end
      E_SI: begin
        if (lt_piv) begin
          i <= i_inc;
        end else begin
          vi <= rd_data;
          j  <= j_dec;
        end
      end
      E_SJ: begin
        if (gt_piv) begin
          j <= j_dec;
        end
      end
      E_SW: i <= i_inc;
      E_FIN: begin
        res_value <= q;
        if (j > k) begin
          hi <= j_dec;
        end
        if (j < k) begin
          lo <= i;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

>>> design/kth_smallest_select_unit.sv
// Top level of the k-th smallest select unit: load control, rank register,
// output register. Depends on kss_pkg, kss_ram and kss_engine.
`default_nettype none

// Channel   Direction  Handshake          Payload
// s_*       in         s_tvalid/s_tready  s_tdata = sample, s_tlast = last
// m_*       out        m_tvalid/m_tready  m_tdata = selected, m_tuser = status
// cfg_*     in         cfg_valid/cfg_ready cfg_data = rank
//
// Samples load at one request per cycle into a 1-read/1-write sample RAM.
// The request marked last closes the set; the quickselect engine then makes
// one RAM read per scanned entry, and no input request is taken until it
// finishes. In the worst case its reads grow quadratically with the count.
// Reset clears the sample count, overflow flag, rank and output valid; the
// sample RAM is not cleared. Loading continues while a result waits on m_tready;
// only a last request stalls until the output register is free.

module kth_smallest_select_unit
  import kss_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  // Input samples.
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [SAMPLE_W-1:0] s_tdata,   // [31:0] sample
  input  logic                s_tlast,   // last
  // Results.
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [SAMPLE_W-1:0] m_tdata,   // [31:0] selected
  output logic [1:0]          m_tuser,   // [1:0] status
  // Rank register write.
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [RANK_W-1:0]   cfg_data
);

  localparam int AW    = $clog2(MAX_ITEMS);
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int CMP_W = (CNT_W > RANK_W) ? CNT_W : RANK_W;

  top_state_t state, state_next;

  logic [CNT_W-1:0]    count;
  logic                overflow;
  logic [RANK_W-1:0]   rank;
  logic [SAMPLE_W-1:0] selected;
  status_t             status;

  logic             out_free, in_fire, has_room, ovf_any, rank_big, eng_start;
  logic [CNT_W-1:0] count_inc;
  logic [CMP_W-1:0] rank_ext;
  logic [AW-1:0]    last_idx;

  kss_result_t         eng_result;
  logic                eng_we, ram_we;
  logic [AW-1:0]       eng_waddr, ram_waddr, ram_raddr;
  logic [SAMPLE_W-1:0] eng_wdata, ram_wdata, ram_rdata;

  // The user must write the rank register only while idle; the block does not enforce it.
  assign cfg_ready = 1'b1;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == TOP_LOAD) && (!s_tlast || out_free);
  assign in_fire  = s_tvalid && s_tready;

  // Samples past capacity are dropped and remembered for the status.
  assign has_room  = (count < CNT_W'(MAX_ITEMS));
  assign count_inc = count + CNT_W'(has_room);
  assign ovf_any   = overflow || !has_room;
  assign rank_ext  = CMP_W'(rank);
  assign rank_big  = (rank_ext >= CMP_W'(count_inc));
  assign last_idx  = AW'(count_inc - CNT_W'(1));
  assign eng_start = in_fire && s_tlast && !ovf_any && !rank_big;

  assign m_tdata = selected;
  assign m_tuser = status;

  // Load writes and engine writes never overlap: one per state.
  assign ram_we    = (in_fire && has_room) || eng_we;
  assign ram_waddr = (state == TOP_LOAD) ? count[AW-1:0] : eng_waddr;
  assign ram_wdata = (state == TOP_LOAD) ? s_tdata : eng_wdata;

  kss_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_ITEMS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  kss_engine #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .start     (eng_start),
    .last_idx  (last_idx),
    .rank_idx  (rank_ext[AW-1:0]),
    .result    (eng_result),
    .ram_we    (eng_we),
    .ram_waddr (eng_waddr),
    .ram_wdata (eng_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= TOP_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      TOP_LOAD: begin
        if (eng_start) begin
          state_next = TOP_SELECT;
        end
      end
      TOP_SELECT: begin
        if (eng_result.valid) begin
          state_next = TOP_LOAD;
        end
      end
      default: state_next = TOP_LOAD;
    endcase
  end

  // Set bookkeeping and the rank register.
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      overflow <= 1'b0;
      rank     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        rank <= cfg_data;
      end
      if (in_fire) begin
        if (s_tlast) begin
          count    <= '0;
          overflow <= 1'b0;
        end else begin
          count    <= count_inc;
          overflow <= ovf_any;
        end
      end
    end
  end

  // Output register. Error results are written straight from the last request;
  // a selected sample arrives from the engine, while the register is empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if ((in_fire && s_tlast && !eng_start) || eng_result.valid) begin
        m_tvalid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (eng_result.valid) begin
      selected <= eng_result.value;
      status   <= STATUS_OK;
    end else if (in_fire && s_tlast && !eng_start) begin
      selected <= '0;
      status   <= ovf_any ? STATUS_OVERFLOW : STATUS_RANK;
    end
  end

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Self-checking bench for kth_smallest_select_unit: streams sets of signed samples,
// predicts the ascending rank-k sample of each set and compares every result.
// Depends on kss_pkg and the design sources under design/.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import kss_pkg::*;

  localparam int CAPACITY      = MAX_ITEMS_DEF;
  localparam int RANDOM_ITEMS  = 200;
  localparam int SETTLE_CYCLES = 16;   // quiet time before touching the rank register
  localparam int HOLD_CYCLES   = 400;  // long receiver hold-off in the pressure test

  // One expected result: the selected sample and its status code.
  typedef struct packed {
    logic [SAMPLE_W-1:0] selected;
    status_t             status;
  } selection_t;

  // How the samples of one set are chosen.
  typedef enum int {
    FILL_RANDOM,
    FILL_NARROW,
    FILL_RISING,
    FILL_FALLING,
    FILL_EXTREMES
  } fill_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [SAMPLE_W-1:0] s_tdata = '0;   // [31:0] sample
  logic                s_tlast = 1'b0; // last
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [SAMPLE_W-1:0] m_tdata;        // [31:0] selected
  logic [1:0]          m_tuser;        // [1:0] status
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [RANK_W-1:0]   cfg_data = '0;

  // Predictor state: the samples of the current set, the drop flag and the rank.
  int                  held[CAPACITY];
  int unsigned         held_count  = 0;
  bit                  dropped_any = 1'b0;
  logic [RANK_W-1:0]   rank_reg    = '0;

  // Results the block still owes, oldest first.
  selection_t          pending[$];
  selection_t          head;

  // Run control shared between the stimulus and the receiver process.
  int                  gap_odds      = 0;   // 0 = sender never idles, else 1 in gap_odds
  bit                  quiet         = 1'b0;
  bit                  hold_request  = 1'b0;
  bit                  holding       = 1'b0;
  int                  mismatches    = 0;
  int                  results_seen  = 0;
  int                  samples_sent  = 0;
  int                  sets_sent     = 0;
  int                  status_tally[3];

  kth_smallest_select_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // Sorts a copy of the current set and returns the sample of ascending rank k.
  // Any correct selection algorithm lands on the same value, so the block's
  // quickselect order of swaps does not matter here.
  function automatic logic [SAMPLE_W-1:0] kth_smallest(int unsigned count, int unsigned k);
    int work[CAPACITY];
    int v;
    int j;
    for (int i = 0; i < count; i++) work[i] = held[i];
    for (int i = 1; i < count; i++) begin
      v = work[i];
      j = i - 1;
      while (j >= 0 && work[j] > v) begin
        work[j + 1] = work[j];
        j--;
      end
      work[j + 1] = v;
    end
    return work[k];
  endfunction

  // Applies one accepted request to the predictor. A request marked last closes
  // the set and queues the result the block has to produce for it.
  function automatic void predict_sample(logic [SAMPLE_W-1:0] value, bit last);
    selection_t r;
    if (held_count < CAPACITY) begin
      held[held_count] = value;
      held_count++;
    end else begin
      // The store is full: the sample is lost and the whole set is flagged.
      dropped_any = 1'b1;
    end
    if (!last) return;
    r.selected = '0;
    if (dropped_any) begin
      // Overflow wins over the rank check.
      r.status = STATUS_OVERFLOW;
    end else if (rank_reg >= held_count) begin
      r.status = STATUS_RANK;
    end else begin
      r.status   = STATUS_OK;
      r.selected = kth_smallest(held_count, rank_reg);
    end
    pending.push_back(r);
    status_tally[int'(r.status)]++;
    held_count  = 0;
    dropped_any = 1'b0;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    mismatches++;
  endtask

  // Result checker: every accepted result is matched against the oldest
  // outstanding prediction, field by field.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending.size() == 0) begin
        report_mismatch($sformatf("result with nothing outstanding: selected %h status %0d",
                                  m_tdata, m_tuser));
      end else begin
        head = pending.pop_front();
        results_seen++;
        if (m_tdata !== head.selected)
          report_mismatch($sformatf("result %0d selected %h, predicted %h",
                                    results_seen, m_tdata, head.selected));
        if (m_tuser !== head.status)
          report_mismatch($sformatf("result %0d status %0d, predicted %0d",
                                    results_seen, m_tuser, head.status));
      end
    end
  end

  // Receiver: ready comes and goes in random bursts. On request it holds off
  // for a long, counted stretch so the block's output register fills and the
  // next closing request is stalled. In quiet mode it never stalls.
  initial begin
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        holding      = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holding = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // Offers one sample, with a random idle burst ahead of it when the current
  // phase allows, and waits until the block takes it. Valid is left high so a
  // following request can go out on the very next edge.
  task automatic send_sample(input logic [SAMPLE_W-1:0] value, input bit last);
    int gap;
    gap = 0;
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) gap = $urandom_range(1, 16);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    predict_sample(value, last);
    samples_sent++;
  endtask

  // Lowers valid and waits until every predicted result has come back, then
  // lets the block settle before anything touches the rank register.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_rank(input logic [RANK_W-1:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    rank_reg = value;
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_value(fill_t fill, int idx);
    case (fill)
      FILL_NARROW:  return $urandom_range(0, 7) - 4;  // plenty of duplicates
      FILL_RISING:  return idx * 3 - 40;
      FILL_FALLING: return 40 - idx * 5;
      FILL_EXTREMES: begin
        case ($urandom_range(0, 3))
          0:       return 32'h8000_0000;
          1:       return 32'h7FFF_FFFF;
          2:       return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default:      return $urandom;
    endcase
  endfunction

  task automatic send_set(input int count, input fill_t fill);
    for (int i = 0; i < count; i++) send_sample(pick_value(fill, i), i == count - 1);
    sets_sent++;
  endtask

  // Short hand-picked sets: field extremes, single and two-sample sets,
  // duplicates, and a rank beyond the set size.
  task automatic test_directed();
    gap_odds = 4;
    // Rank still holds its reset value of zero here.
    send_sample(32'd5, 1'b0);
    send_sample(-32'sd3, 1'b0);
    send_sample(32'd7, 1'b1);
    sets_sent++;
    write_rank(8'd0);
    send_sample(32'h8000_0000, 1'b1);
    send_sample(32'h7FFF_FFFF, 1'b1);
    sets_sent += 2;
    write_rank(8'd1);
    send_sample(32'd9, 1'b1);                  // one sample, rank 1: rank error
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'h8000_0000, 1'b1);
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'h0000_0000, 1'b1);
    send_set(4, FILL_NARROW);
    sets_sent += 3;
    write_rank(8'd2);
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h0000_0000, 1'b0);
    send_sample(32'h0000_0001, 1'b1);
    sets_sent++;
    write_rank(8'd255);
    send_set(3, FILL_EXTREMES);                // far beyond the count
  endtask

  // A set that exactly fills the store, then a set that overflows it, then a
  // small set to show the drop flag was cleared.
  task automatic test_capacity();
    gap_odds = 8;
    write_rank(8'd255);
    send_set(CAPACITY, FILL_RANDOM);           // rank 255 picks the maximum
    write_rank(8'd0);
    send_set(CAPACITY + 1, FILL_NARROW);
    send_set(3, FILL_RANDOM);
  endtask

  // The receiver holds off for a long time while the sender keeps offering
  // sets; the second closing request has to wait for the output register.
  task automatic test_backpressure();
    write_rank(8'd2);
    gap_odds     = 0;
    hold_request = 1'b1;
    wait (holding);
    repeat (3) send_set(12, FILL_RANDOM);
  endtask

  // Random phases: a rank per phase, then a few sets of random shape. Most sets
  // are small; a few are large to exercise deep partitioning.
  task automatic test_random_sets();
    int count;
    int pick;
    int random_items;
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 10)      write_rank(8'd0);
      else if (pick < 15) write_rank(8'd255);
      else if (pick < 25) write_rank(RANK_W'($urandom_range(0, 255)));
      else                write_rank(RANK_W'($urandom_range(0, 20)));
      case ($urandom_range(0, 2))
        0:       gap_odds = 0;
        1:       gap_odds = 3;
        default: gap_odds = 10;
      endcase
      repeat ($urandom_range(1, 6)) begin
        pick = $urandom_range(0, 99);
        if (pick < 90)      count = $urandom_range(1, 24);
        else if (pick < 98) count = $urandom_range(25, 64);
        else                count = $urandom_range(100, 200);
        send_set(count, fill_t'($urandom_range(0, 4)));
        random_items += count;
      end
    end
  endtask

  // Closing stretch at full rate on both sides.
  task automatic test_steady_stream();
    quiet    = 1'b1;
    gap_odds = 0;
    write_rank(8'd3);
    repeat (4) send_set(12, FILL_RANDOM);
    write_rank(8'd0);
    repeat (4) send_set($urandom_range(1, 8), FILL_RANDOM);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_capacity();
    test_backpressure();
    test_random_sets();
    test_steady_stream();
    wait_idle();
    repeat (40) @(posedge clk);
    $display("Covered %0d samples in %0d sets: %0d selections, %0d rank errors, %0d overflows.",
             samples_sent, sets_sent, status_tally[0], status_tally[1], status_tally[2]);
    $display("Checked %0d results, including one %0d-cycle receiver hold-off.",
             results_seen, HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #40ms;
    $display("Timeout with %0d results outstanding", pending.size());
    $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
design/kss_pkg.sv
design/kss_ram.sv
design/kss_engine.sv
design/kth_smallest_select_unit.sv
tb/testbench.sv
